// File: src/bkt_pkg.sv
// Shared types, constants and the keyword table of the keyword tokenizer.
// No dependencies.
package bkt_pkg;

   localparam int MATCH_SPAN = 7;
   localparam int KEY_COUNT  = 76;

   localparam logic [7:0] TOKEN_BASE = 8'h80;
   localparam logic [7:0] TOKEN_DATA = 8'h83;
   localparam logic [7:0] TOKEN_REM  = 8'h8F;
   localparam logic [7:0] LINE_END   = 8'h00;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      logic append;
      logic resolve;
      logic term;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic can_emit;
   } status_type;

   // Keyword text, right-justified, first char in the highest used byte.
   function automatic logic [55:0] kw_text(input int k);
      logic [55:0] t;
      unique case (k)
         0: t = "END";      1: t = "FOR";      2: t = "NEXT";     3: t = "DATA";
         4: t = "INPUT#";   5: t = "INPUT";    6: t = "DIM";      7: t = "READ";
         8: t = "LET";      9: t = "GOTO";     10: t = "RUN";     11: t = "IF";
         12: t = "RESTORE"; 13: t = "GOSUB";   14: t = "RETURN";  15: t = "REM";
         16: t = "STOP";    17: t = "ON";      18: t = "WAIT";    19: t = "LOAD";
         20: t = "SAVE";    21: t = "VERIFY";  22: t = "DEF";     23: t = "POKE";
         24: t = "PRINT#";  25: t = "PRINT";   26: t = "CONT";    27: t = "LIST";
         28: t = "CLR";     29: t = "CMD";     30: t = "SYS";     31: t = "OPEN";
         32: t = "CLOSE";   33: t = "GET";     34: t = "NEW";     35: t = "TAB(";
         36: t = "TO";      37: t = "FN";      38: t = "SPC(";    39: t = "THEN";
         40: t = "NOT";     41: t = "STEP";    42: t = "+";       43: t = "-";
         44: t = "*";       45: t = "/";       46: t = "^";       47: t = "AND";
         48: t = "OR";      49: t = ">";       50: t = "=";       51: t = "<";
         52: t = "SGN";     53: t = "INT";     54: t = "ABS";     55: t = "USR";
         56: t = "FRE";     57: t = "POS";     58: t = "SQR";     59: t = "RND";
         60: t = "LOG";     61: t = "EXP";     62: t = "COS";     63: t = "SIN";
         64: t = "TAN";     65: t = "ATN";     66: t = "PEEK";    67: t = "LEN";
         68: t = "STR$";    69: t = "VAL";     70: t = "ASC";     71: t = "CHR$";
         72: t = "LEFT$";   73: t = "RIGHT$";  74: t = "MID$";    75: t = "GO";
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [2:0] kw_len(input int k);
      logic [55:0] t;
      logic [2:0]  n;
      t = kw_text(k);
      n = '0;
      for (int i = 0; i < MATCH_SPAN; i++) begin
         if (t[8*i +: 8] != 8'h00) n = n + 3'd1;
      end
      return n;
   endfunction

   function automatic logic [7:0] kw_char(input int k, input int n);
      logic [55:0] t;
      int          l;
      t = kw_text(k);
      l = int'(kw_len(k));
      return t[8*(l-1-n) +: 8];
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
   endfunction

endpackage

// File: src/bkt_ifs.sv
// Valid/ready channel interfaces for the keyword tokenizer.
// No dependencies.
interface bkt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       line_done;
   modport source (output valid, char_code, line_done, input ready);
   modport sink (input valid, char_code, line_done, output ready);
endinterface

interface bkt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   modport source (output valid, out_byte, last, input ready);
   modport sink (input valid, out_byte, last, output ready);
endinterface

// File: src/bkt_ctrl.sv
// Sequencing state machine of the keyword tokenizer.
// Depends on bkt_pkg.
module bkt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_line_done,
   output logic                  req_ready,
   input  bkt_pkg::status_type   status,
   output bkt_pkg::cmd_type      cmd
);

   localparam logic [1:0] S_RUN   = 2'd0;
   localparam logic [1:0] S_DRAIN = 2'd1;
   localparam logic [1:0] S_TERM  = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         S_RUN: begin
            if (status.full) begin
               cmd.resolve = status.can_emit;
            end else begin
               req_ready = 1'b1;
               if (req_valid) begin
                  if (req_line_done) state_in = S_DRAIN;
                  else cmd.append = 1'b1;
               end
            end
         end
         S_DRAIN: begin
            if (status.empty) state_in = S_TERM;
            else cmd.resolve = status.can_emit;
         end
         S_TERM: begin
            if (status.can_emit) begin
               cmd.term = 1'b1;
               state_in = S_RUN;
            end
         end
         default: state_in = S_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_RUN;
      else state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.append, cmd.resolve, cmd.term}))
      else $error("more than one datapath command");
   a_no_take_full: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !req_ready)
      else $error("input taken while window full");
   a_term_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.term |-> status.empty)
      else $error("terminator before window drained");
`endif

endmodule

// File: src/bkt_dp.sv
// Lookahead window, keyword matcher, mode flags and output register.
// Depends on bkt_pkg.
module bkt_dp #(
   parameter int WINDOW_DEPTH = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            char_code,
   input  bkt_pkg::cmd_type      cmd,
   output bkt_pkg::status_type   status,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last
);

   localparam int CW = $clog2(WINDOW_DEPTH + 1);
   localparam int IW = $clog2(WINDOW_DEPTH);
   localparam int KC = bkt_pkg::KEY_COUNT;
   localparam int MS = bkt_pkg::MATCH_SPAN;

   logic [7:0]    win_ff [WINDOW_DEPTH];
   logic [7:0]    win_in [WINDOW_DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic          str_ff, str_in, rem_ff, rem_in, data_ff, data_in;
   logic          ovalid_ff, ovalid_in;
   logic [7:0]    obyte_ff, obyte_in;
   logic          olast_ff, olast_in;

   logic [KC-1:0] kw_ok;
   logic          hit;
   logic [6:0]    hit_idx;
   logic [2:0]    hit_len;
   logic [7:0]    head, tok;
   logic          emit;
   logic [7:0]    emit_byte;
   logic [2:0]    used;

   assign head = win_ff[0];

   // Parallel compare of every keyword against the window head.
   always_comb begin
      for (int k = 0; k < KC; k++) begin
         kw_ok[k] = (CW'(bkt_pkg::kw_len(k)) <= count_ff);
         for (int n = 0; n < MS; n++) begin
            if (n < int'(bkt_pkg::kw_len(k)) &&
                bkt_pkg::to_upper(win_ff[n]) != bkt_pkg::kw_char(k, n))
               kw_ok[k] = 1'b0;
         end
      end
      hit     = 1'b0;
      hit_idx = '0;
      hit_len = '0;
      for (int k = KC - 1; k >= 0; k--) begin
         if (kw_ok[k]) begin
            hit     = 1'b1;
            hit_idx = 7'(k);
            hit_len = bkt_pkg::kw_len(k);
         end
      end
   end

   assign tok = bkt_pkg::TOKEN_BASE + {1'b0, hit_idx};

   always_comb begin
      emit      = 1'b1;
      emit_byte = head;
      used      = 3'd1;
      str_in    = str_ff;
      rem_in    = rem_ff;
      data_in   = data_ff;
      if (str_ff) begin
         if (head == bkt_pkg::CHAR_QUOTE) str_in = 1'b0;
      end else if (head == bkt_pkg::CHAR_QUOTE) begin
         str_in = 1'b1;
      end else if (rem_ff) begin
         emit = 1'b1;
      end else if (data_ff) begin
         if (head == bkt_pkg::CHAR_COLON) data_in = 1'b0;
      end else if (hit) begin
         emit_byte = tok;
         used      = hit_len;
         if (tok == bkt_pkg::TOKEN_REM) rem_in = 1'b1;
         if (tok == bkt_pkg::TOKEN_DATA) data_in = 1'b1;
      end else begin
         emit      = (head != bkt_pkg::CHAR_SPACE);
         emit_byte = bkt_pkg::to_upper(head);
      end
      if (!cmd.resolve) begin
         str_in  = str_ff;
         rem_in  = rem_ff;
         data_in = data_ff;
      end
      if (cmd.term) begin
         str_in  = 1'b0;
         rem_in  = 1'b0;
         data_in = 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         win_in[i] = win_ff[i];
         if (cmd.resolve) begin
            for (int m = 1; m <= MS; m++) begin
               if (used == 3'(m) && i + m < WINDOW_DEPTH) win_in[i] = win_ff[i + m];
            end
         end
      end
      if (cmd.append) win_in[count_ff[IW-1:0]] = char_code;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.append) count_in = count_ff + CW'(1);
      else if (cmd.resolve) count_in = count_ff - CW'(used);
   end

   always_comb begin
      ovalid_in = ovalid_ff && !rsp_ready;
      obyte_in  = obyte_ff;
      olast_in  = olast_ff;
      if (cmd.resolve && emit) begin
         ovalid_in = 1'b1;
         obyte_in  = emit_byte;
         olast_in  = 1'b0;
      end else if (cmd.term) begin
         ovalid_in = 1'b1;
         obyte_in  = bkt_pkg::LINE_END;
         olast_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      obyte_ff <= obyte_in;
      olast_ff <= olast_in;
      if (reset) begin
         count_ff  <= '0;
         str_ff    <= 1'b0;
         rem_ff    <= 1'b0;
         data_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         str_ff    <= str_in;
         rem_ff    <= rem_in;
         data_ff   <= data_in;
         ovalid_ff <= ovalid_in;
      end
   end

   assign status.full     = (count_ff == CW'(MS));
   assign status.empty    = (count_ff == '0);
   assign status.can_emit = !ovalid_ff || rsp_ready;
   assign rsp_valid       = ovalid_ff;
   assign rsp_out_byte    = obyte_ff;
   assign rsp_last        = olast_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MS))
      else $error("window count past match span");
   a_last_zero: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && olast_ff) |-> (obyte_ff == bkt_pkg::LINE_END))
      else $error("terminator byte not zero");
   a_modes_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.term |=> (!str_ff && !rem_ff && !data_ff))
      else $error("modes survive end of line");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && !rsp_ready) |-> (!cmd.term && !cmd.resolve))
      else $error("output register overwritten");
`endif

endmodule

// File: src/basic_keyword_tokenizer.sv
// Keyword tokenizer: one source character per transfer, or an end-of-line mark.
// A character transfer is taken while fewer than seven characters are held;
// once seven are held, the controller resolves the window head before it
// takes a further character. End of line takes its own transfer; the
// controller then resolves the head entry until the window is empty (a keyword
// clears all of its characters in one resolve step) and then writes the
// terminator. Every result waits in one output register; the sequencer stalls
// while it is full and not being taken.
// Depends on bkt_pkg, bkt_ifs, bkt_ctrl and bkt_dp.
module basic_keyword_tokenizer #(
   parameter int WINDOW_DEPTH = 7
) (
   input  logic       clock,
   input  logic       reset,
   bkt_req_if.sink    req_if,
   bkt_rsp_if.source  rsp_if
);

   bkt_pkg::cmd_type    cmd;
   bkt_pkg::status_type status;

   bkt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_line_done (req_if.line_done),
      .req_ready     (req_if.ready),
      .status        (status),
      .cmd           (cmd)
   );

   bkt_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .char_code    (req_if.char_code),
      .cmd          (cmd),
      .status       (status),
      .rsp_ready    (rsp_if.ready),
      .rsp_valid    (rsp_if.valid),
      .rsp_out_byte (rsp_if.out_byte),
      .rsp_last     (rsp_if.last)
   );

endmodule
